### hw/rtl/stack_machine_executor_unit_defines.svh
// assertion macros shared by the executor modules
`ifndef STACK_MACHINE_EXECUTOR_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sme_pkg.sv
// package: opcodes, status codes, word types and control structs of the executor
package sme_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int CALL_DEPTH_DEF  = 256;
    localparam int LABEL_BITS_DEF  = 8;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int REG_COUNT_DEF   = 16;

    localparam logic [7:0] OP_HALT  = 8'h00;
    localparam logic [7:0] OP_DEBUG = 8'h01;
    localparam logic [7:0] OP_MOVL  = 8'h08;
    localparam logic [7:0] OP_MOVR  = 8'h09;
    localparam logic [7:0] OP_PUSH  = 8'h10;
    localparam logic [7:0] OP_DUP   = 8'h11;
    localparam logic [7:0] OP_DROP  = 8'h12;
    localparam logic [7:0] OP_SWAP  = 8'h13;
    localparam logic [7:0] OP_LD    = 8'h20;
    localparam logic [7:0] OP_ST    = 8'h21;
    localparam logic [7:0] OP_ADD   = 8'h30;
    localparam logic [7:0] OP_SUB   = 8'h31;
    localparam logic [7:0] OP_MUL   = 8'h32;
    localparam logic [7:0] OP_DIV   = 8'h33;
    localparam logic [7:0] OP_MOD   = 8'h34;
    localparam logic [7:0] OP_LABEL = 8'hA0;
    localparam logic [7:0] OP_CALL  = 8'hA1;
    localparam logic [7:0] OP_JMP   = 8'hA2;
    localparam logic [7:0] OP_JZ    = 8'hA3;
    localparam logic [7:0] OP_JNZ   = 8'hA4;
    localparam logic [7:0] OP_JPOS  = 8'hA5;
    localparam logic [7:0] OP_JNEG  = 8'hA6;
    localparam logic [7:0] OP_RET   = 8'hA7;
    localparam logic [7:0] OP_PUTN  = 8'hB0;
    localparam logic [7:0] OP_PUTC  = 8'hB1;

    localparam logic [3:0] ST_RUN   = 4'd0;
    localparam logic [3:0] ST_END   = 4'd1;
    localparam logic [3:0] ST_HALT  = 4'd2;
    localparam logic [3:0] ST_OVF   = 4'd3;
    localparam logic [3:0] ST_UNF   = 4'd4;
    localparam logic [3:0] ST_COVF  = 4'd5;
    localparam logic [3:0] ST_CUNF  = 4'd6;
    localparam logic [3:0] ST_BADOP = 4'd7;
    localparam logic [3:0] ST_DIVZ  = 4'd8;

    localparam logic [2:0] OK_NONE  = 3'd0;
    localparam logic [2:0] OK_NUM   = 3'd1;
    localparam logic [2:0] OK_CHAR  = 3'd2;
    localparam logic [2:0] OK_DEBUG = 3'd3;
    localparam logic [2:0] OK_HALT  = 3'd4;

    typedef struct packed {
        logic               kind;
        logic [7:0]         opcode;
        logic [3:0]         dest_reg;
        logic [3:0]         src_reg;
        logic signed [63:0] literal;
        logic [7:0]         label_id;
        logic [15:0]        label_target;
    } item_t;

    typedef struct packed {
        logic [3:0]         status;
        logic [15:0]        next_ip;
        logic [2:0]         out_kind;
        logic signed [63:0] out_value;
        logic [8:0]         stack_depth;
        logic [8:0]         call_depth;
    } result_t;

    typedef struct packed {
        logic [15:0] program_size;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic load_in;
        logic read;
        logic md_start;
        logic commit;
        logic wr2;
    } sme_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic md_go;
        logic swap;
        logic md_done;
        logic out_free;
    } sme_sts_t;

endpackage

### hw/rtl/sme_chan_if.sv
// valid/ready channel carrying one word of type T
interface sme_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/stack_machine_executor_unit.sv
// Stack machine executor: takes one decoded instruction word (or label definition) per
// handshake and returns one result word with status, next fetch address, output and
// stack depths. Most words pass the steps accept, memory read, execute and write-back;
// swap adds a step because the data stack has a single write port; mul, div and mod wait
// on the shared 64-step shift-add multiplier / restoring divider.
// After reset a clearing pass over max(2**LABEL_BITS, REG_COUNT) entries (256 by default)
// zeroes the label table and register file; no words are taken meanwhile, while
// program_size writes are taken at any time. Any final status holds until reset.
module stack_machine_executor_unit #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int CALL_DEPTH  = sme_pkg::CALL_DEPTH_DEF,
    parameter int LABEL_BITS  = sme_pkg::LABEL_BITS_DEF,
    parameter int ADDR_BITS   = sme_pkg::ADDR_BITS_DEF,
    parameter int REG_COUNT   = sme_pkg::REG_COUNT_DEF
) (
    input logic          clk,
    input logic          rst_n,
    sme_chan_if.sink     cfg,
    sme_chan_if.sink     instr,
    sme_chan_if.source   result
);

    sme_pkg::sme_cmd_t cmd;
    sme_pkg::sme_sts_t sts;
    logic              in_ready;
    logic              md_is_mul;
    logic              md_want_rem;
    logic [63:0]       md_a;
    logic [63:0]       md_b;
    logic              md_done;
    logic [63:0]       md_result;

    assign cfg.ready   = 1'b1;
    assign instr.ready = in_ready;

    sme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sme_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .CALL_DEPTH  (CALL_DEPTH),
        .LABEL_BITS  (LABEL_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .REG_COUNT   (REG_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .in_data     (instr.data),
        .cmd         (cmd),
        .sts         (sts),
        .md_is_mul   (md_is_mul),
        .md_want_rem (md_want_rem),
        .md_a        (md_a),
        .md_b        (md_b),
        .md_done     (md_done),
        .md_result   (md_result),
        .out_valid   (result.valid),
        .out_data    (result.data),
        .out_ready   (result.ready)
    );

    sme_muldiv u_md (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.md_start),
        .is_mul   (md_is_mul),
        .want_rem (md_want_rem),
        .a        (md_a),
        .b        (md_b),
        .done     (md_done),
        .result   (md_result)
    );

endmodule

### hw/rtl/sme_muldiv.sv
// iterative 64-bit multiplier and signed divider, one bit per cycle
module sme_muldiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_mul,
    input  logic        want_rem,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg;
    logic        fix_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] sh_reg;
    logic [63:0] opd_reg;
    logic        mul_reg;
    logic        rem_reg;
    logic        neg_reg;
    logic [63:0] res_reg;
    logic [63:0] trial;
    logic [63:0] fin_val;

    assign trial   = {acc_reg[62:0], sh_reg[63]};
    assign fin_val = mul_reg ? acc_reg : (rem_reg ? acc_reg : sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg && !fix_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                fix_reg <= 1'b1;
            end
        end
        else if (fix_reg)
        begin
            fix_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mul_reg <= is_mul;
            rem_reg <= want_rem;
            acc_reg <= '0;
            if (is_mul)
            begin
                sh_reg  <= b;
                opd_reg <= a;
                neg_reg <= 1'b0;
            end
            else
            begin
                sh_reg  <= a[63] ? (64'd0 - a) : a;
                opd_reg <= b[63] ? (64'd0 - b) : b;
                neg_reg <= want_rem ? a[63] : (a[63] ^ b[63]);
            end
        end
        else if (busy_reg && !fix_reg)
        begin
            if (mul_reg)
            begin
                if (sh_reg[0])
                begin
                    acc_reg <= acc_reg + opd_reg;
                end
                opd_reg <= {opd_reg[62:0], 1'b0};
                sh_reg  <= {1'b0, sh_reg[63:1]};
            end
            else if (trial >= opd_reg)
            begin
                acc_reg <= trial - opd_reg;
                sh_reg  <= {sh_reg[62:0], 1'b1};
            end
            else
            begin
                acc_reg <= trial;
                sh_reg  <= {sh_reg[62:0], 1'b0};
            end
        end
        else if (fix_reg)
        begin
            res_reg <= neg_reg ? (64'd0 - fin_val) : fin_val;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### hw/rtl/sme_datapath.sv
// datapath: machine state, stacks, register file, label table and result register
`include "stack_machine_executor_unit_defines.svh"

module sme_datapath #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int CALL_DEPTH  = sme_pkg::CALL_DEPTH_DEF,
    parameter int LABEL_BITS  = sme_pkg::LABEL_BITS_DEF,
    parameter int ADDR_BITS   = sme_pkg::ADDR_BITS_DEF,
    parameter int REG_COUNT   = sme_pkg::REG_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  sme_pkg::cfg_t     cfg_data,
    input  sme_pkg::item_t    in_data,
    input  sme_pkg::sme_cmd_t cmd,
    output sme_pkg::sme_sts_t sts,
    output logic              md_is_mul,
    output logic              md_want_rem,
    output logic [63:0]       md_a,
    output logic [63:0]       md_b,
    input  logic              md_done,
    input  logic [63:0]       md_result,
    output logic              out_valid,
    output sme_pkg::result_t  out_data,
    input  logic              out_ready
);

    localparam int SDW   = $clog2(STACK_DEPTH + 1);
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam int CDW   = $clog2(CALL_DEPTH + 1);
    localparam int CIW   = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int RW    = $clog2(REG_COUNT);
    localparam int LC    = 1 << LABEL_BITS;
    localparam int CLR_N = (LC > REG_COUNT) ? LC : REG_COUNT;
    localparam int CLW   = $clog2(CLR_N);

    logic [15:0]           psize_reg;
    logic [ADDR_BITS-1:0]  ip_reg;
    logic [SDW-1:0]        dtop_reg;
    logic [CDW-1:0]        rtop_reg;
    logic [3:0]            stat_reg;
    logic                  out_valid_reg;
    logic [CLW-1:0]        clr_cnt_reg;

    logic                  kind_reg;
    logic [7:0]            op_reg;
    logic [RW-1:0]         dst_reg;
    logic [RW-1:0]         src_reg;
    logic [63:0]           lit_reg;
    logic [LABEL_BITS-1:0] lab_reg;
    logic [ADDR_BITS-1:0]  tgt_reg;
    logic [63:0]           a_reg;
    logic [63:0]           b_reg;
    logic [63:0]           r_reg;
    logic [ADDR_BITS-1:0]  l_reg;
    logic [ADDR_BITS-1:0]  t_reg;
    sme_pkg::result_t      out_data_reg;

    logic [63:0]           ds_mem [STACK_DEPTH];
    logic [ADDR_BITS-1:0]  rs_mem [CALL_DEPTH];
    logic [63:0]           rf_mem [REG_COUNT];
    logic [ADDR_BITS-1:0]  lt_mem [LC];

    logic [SDW-1:0]        d_m1;
    logic [SDW-1:0]        d_m2;
    logic [CDW-1:0]        r_m1;
    logic                  lt1;
    logic                  lt2;
    logic                  full;
    logic                  rfull;
    logic                  at_end;
    logic                  run;
    logic                  wr_ok;
    logic [RW-1:0]         rd_idx;

    logic [3:0]            err;
    logic [ADDR_BITS-1:0]  nip;
    logic [SDW-1:0]        d_next;
    logic [CDW-1:0]        rt_next;
    logic                  ds_we;
    logic [SIW-1:0]        ds_widx;
    logic [63:0]           ds_wdata;
    logic                  rf_we;
    logic [63:0]           rf_wdata;
    logic                  rs_we;
    logic [2:0]            okind;
    logic [63:0]           oval;
    logic                  halt;
    logic                  md_op;
    logic                  swap;
    logic                  take;
    logic [63:0]           arith;

    logic [3:0]            stat_next;
    logic [ADDR_BITS-1:0]  ip_next;
    logic [SDW-1:0]        dtop_next;
    logic [CDW-1:0]        rtop_next;
    sme_pkg::result_t      res_next;

    function automatic logic [RW-1:0] reg_idx(input logic [3:0] v);
        logic [8:0] t;
        t = {5'd0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 9'(REG_COUNT))
            begin
                t = t - 9'(REG_COUNT);
            end
        end
        return RW'(t);
    endfunction

    assign d_m1   = dtop_reg - SDW'(1);
    assign d_m2   = dtop_reg - SDW'(2);
    assign r_m1   = rtop_reg - CDW'(1);
    assign lt1    = (dtop_reg == '0);
    assign lt2    = (dtop_reg < SDW'(2));
    assign full   = (32'(dtop_reg) >= STACK_DEPTH);
    assign rfull  = (32'(rtop_reg) >= CALL_DEPTH);
    assign at_end = (32'(ip_reg) >= 32'(psize_reg));
    assign run    = !kind_reg && (stat_reg == sme_pkg::ST_RUN) && !at_end;
    assign wr_ok  = run && (err == sme_pkg::ST_RUN);
    assign rd_idx = (op_reg == sme_pkg::OP_MOVR) ? src_reg : dst_reg;

    always_comb
    begin
        case (op_reg)
            sme_pkg::OP_ADD: arith = a_reg + b_reg;
            sme_pkg::OP_SUB: arith = a_reg - b_reg;
            default:         arith = md_result;
        endcase
    end

    // instruction decode and effects
    always_comb
    begin
        err      = sme_pkg::ST_RUN;
        nip      = ip_reg + ADDR_BITS'(1);
        d_next   = dtop_reg;
        rt_next  = rtop_reg;
        ds_we    = 1'b0;
        ds_widx  = dtop_reg[SIW-1:0];
        ds_wdata = lit_reg;
        rf_we    = 1'b0;
        rf_wdata = lit_reg;
        rs_we    = 1'b0;
        okind    = sme_pkg::OK_NONE;
        oval     = '0;
        halt     = 1'b0;
        md_op    = 1'b0;
        swap     = 1'b0;
        take     = 1'b0;
        unique case (op_reg) inside
            sme_pkg::OP_HALT:
            begin
                if (lt1) err = sme_pkg::ST_UNF;
                else
                begin
                    okind  = sme_pkg::OK_HALT;
                    oval   = a_reg;
                    d_next = d_m1;
                    halt   = 1'b1;
                    nip    = ip_reg;
                end
            end
            sme_pkg::OP_DEBUG:
            begin
                okind = sme_pkg::OK_DEBUG;
                oval  = 64'(ip_reg);
            end
            sme_pkg::OP_MOVL:
            begin
                rf_we = 1'b1;
                nip   = ip_reg + ADDR_BITS'(10);
            end
            sme_pkg::OP_MOVR:
            begin
                rf_we    = 1'b1;
                rf_wdata = r_reg;
                nip      = ip_reg + ADDR_BITS'(3);
            end
            sme_pkg::OP_PUSH:
            begin
                if (full) err = sme_pkg::ST_OVF;
                else
                begin
                    ds_we  = 1'b1;
                    d_next = dtop_reg + SDW'(1);
                    nip    = ip_reg + ADDR_BITS'(9);
                end
            end
            sme_pkg::OP_DUP:
            begin
                if (lt1) err = sme_pkg::ST_UNF;
                else if (full) err = sme_pkg::ST_OVF;
                else
                begin
                    ds_we    = 1'b1;
                    ds_wdata = a_reg;
                    d_next   = dtop_reg + SDW'(1);
                end
            end
            sme_pkg::OP_DROP:
            begin
                if (lt1) err = sme_pkg::ST_UNF;
                else d_next = d_m1;
            end
            sme_pkg::OP_SWAP:
            begin
                if (lt2) err = sme_pkg::ST_UNF;
                else
                begin
                    ds_we    = 1'b1;
                    ds_widx  = d_m1[SIW-1:0];
                    ds_wdata = b_reg;
                    swap     = 1'b1;
                end
            end
            sme_pkg::OP_LD:
            begin
                if (full) err = sme_pkg::ST_OVF;
                else
                begin
                    ds_we    = 1'b1;
                    ds_wdata = r_reg;
                    d_next   = dtop_reg + SDW'(1);
                    nip      = ip_reg + ADDR_BITS'(2);
                end
            end
            sme_pkg::OP_ST:
            begin
                if (lt1) err = sme_pkg::ST_UNF;
                else
                begin
                    rf_we    = 1'b1;
                    rf_wdata = a_reg;
                    d_next   = d_m1;
                    nip      = ip_reg + ADDR_BITS'(2);
                end
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
            sme_pkg::OP_DIV, sme_pkg::OP_MOD:
            begin
                if (lt2) err = sme_pkg::ST_UNF;
                else if ((op_reg == sme_pkg::OP_DIV || op_reg == sme_pkg::OP_MOD)
                         && b_reg == '0) err = sme_pkg::ST_DIVZ;
                else
                begin
                    md_op    = (op_reg != sme_pkg::OP_ADD) && (op_reg != sme_pkg::OP_SUB);
                    ds_we    = 1'b1;
                    ds_widx  = d_m2[SIW-1:0];
                    ds_wdata = arith;
                    d_next   = d_m1;
                end
            end
            sme_pkg::OP_LABEL:
            begin
                nip = ip_reg + ADDR_BITS'(3);
            end
            sme_pkg::OP_CALL:
            begin
                if (rfull) err = sme_pkg::ST_COVF;
                else
                begin
                    rs_we   = 1'b1;
                    rt_next = rtop_reg + CDW'(1);
                    nip     = l_reg;
                end
            end
            sme_pkg::OP_JMP:
            begin
                nip = l_reg;
            end
            sme_pkg::OP_JZ, sme_pkg::OP_JNZ, sme_pkg::OP_JPOS, sme_pkg::OP_JNEG:
            begin
                if (lt1) err = sme_pkg::ST_UNF;
                else
                begin
                    d_next = d_m1;
                    case (op_reg)
                        sme_pkg::OP_JZ:   take = (a_reg == '0);
                        sme_pkg::OP_JNZ:  take = (a_reg != '0);
                        sme_pkg::OP_JPOS: take = (a_reg != '0) && !a_reg[63];
                        default:          take = a_reg[63];
                    endcase
                    nip = take ? l_reg : (ip_reg + ADDR_BITS'(3));
                end
            end
            sme_pkg::OP_RET:
            begin
                if (rtop_reg == '0) err = sme_pkg::ST_CUNF;
                else
                begin
                    rt_next = r_m1;
                    nip     = t_reg;
                end
            end
            sme_pkg::OP_PUTN, sme_pkg::OP_PUTC:
            begin
                if (lt1) err = sme_pkg::ST_UNF;
                else
                begin
                    d_next = d_m1;
                    if (op_reg == sme_pkg::OP_PUTN)
                    begin
                        okind = sme_pkg::OK_NUM;
                        oval  = a_reg;
                    end
                    else
                    begin
                        okind = sme_pkg::OK_CHAR;
                        oval  = {56'd0, a_reg[7:0]};
                    end
                end
            end
            default:
            begin
                err = sme_pkg::ST_BADOP;
            end
        endcase
    end

    // state after the step and the result word
    always_comb
    begin
        stat_next = stat_reg;
        ip_next   = ip_reg;
        dtop_next = dtop_reg;
        rtop_next = rtop_reg;
        if (!kind_reg && stat_reg == sme_pkg::ST_RUN)
        begin
            if (at_end)
            begin
                stat_next = sme_pkg::ST_END;
            end
            else if (err != sme_pkg::ST_RUN)
            begin
                stat_next = err;
            end
            else
            begin
                ip_next   = nip;
                dtop_next = d_next;
                rtop_next = rt_next;
                if (halt)
                begin
                    stat_next = sme_pkg::ST_HALT;
                end
                else if (32'(nip) >= 32'(psize_reg))
                begin
                    stat_next = sme_pkg::ST_END;
                end
            end
        end
        res_next.status      = stat_next;
        res_next.next_ip     = 16'(ip_next);
        res_next.out_kind    = wr_ok ? okind : sme_pkg::OK_NONE;
        res_next.out_value   = wr_ok ? oval : 64'd0;
        res_next.stack_depth = 9'(dtop_next);
        res_next.call_depth  = 9'(rtop_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psize_reg     <= '0;
            ip_reg        <= '0;
            dtop_reg      <= '0;
            rtop_reg      <= '0;
            stat_reg      <= sme_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                psize_reg <= cfg_data.program_size;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLW'(1);
            end
            if (cmd.commit)
            begin
                ip_reg   <= ip_next;
                dtop_reg <= dtop_next;
                rtop_reg <= rtop_next;
                stat_reg <= stat_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= in_data.kind;
            op_reg   <= in_data.opcode;
            dst_reg  <= reg_idx(in_data.dest_reg);
            src_reg  <= reg_idx(in_data.src_reg);
            lit_reg  <= in_data.literal;
            lab_reg  <= LABEL_BITS'(in_data.label_id);
            tgt_reg  <= ADDR_BITS'(in_data.label_target);
        end
        if (cmd.commit)
        begin
            out_data_reg <= res_next;
        end
    end

    // data stack: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            a_reg <= ds_mem[d_m1[SIW-1:0]];
            b_reg <= ds_mem[d_m2[SIW-1:0]];
        end
        if (cmd.commit && wr_ok && ds_we)
        begin
            ds_mem[ds_widx] <= ds_wdata;
        end
        else if (cmd.wr2)
        begin
            ds_mem[d_m2[SIW-1:0]] <= a_reg;
        end
    end

    // call stack
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            t_reg <= rs_mem[r_m1[CIW-1:0]];
        end
        if (cmd.commit && wr_ok && rs_we)
        begin
            rs_mem[rtop_reg[CIW-1:0]] <= ip_reg + ADDR_BITS'(3);
        end
    end

    // register file, zeroed by the clearing pass
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            r_reg <= rf_mem[rd_idx];
        end
        if (cmd.clear && (32'(clr_cnt_reg) < REG_COUNT))
        begin
            rf_mem[RW'(clr_cnt_reg)] <= '0;
        end
        else if (cmd.commit && wr_ok && rf_we)
        begin
            rf_mem[dst_reg] <= rf_wdata;
        end
    end

    // label table, zeroed by the clearing pass
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            l_reg <= lt_mem[lab_reg];
        end
        if (cmd.clear && (32'(clr_cnt_reg) < LC))
        begin
            lt_mem[LABEL_BITS'(clr_cnt_reg)] <= '0;
        end
        else if (cmd.commit && kind_reg)
        begin
            lt_mem[lab_reg] <= tgt_reg;
        end
    end

    assign md_is_mul   = (op_reg == sme_pkg::OP_MUL);
    assign md_want_rem = (op_reg == sme_pkg::OP_MOD);
    assign md_a        = a_reg;
    assign md_b        = b_reg;

    assign sts.clear_done = (clr_cnt_reg == CLW'(CLR_N - 1));
    assign sts.md_go      = wr_ok && md_op;
    assign sts.swap       = wr_ok && swap;
    assign sts.md_done    = md_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SME_ASSERT_NOW(a_dtop_range, 1'b1, 32'(dtop_reg) <= STACK_DEPTH, "data stack depth out of range")
    `SME_ASSERT_NOW(a_rtop_range, 1'b1, 32'(rtop_reg) <= CALL_DEPTH, "call stack depth out of range")
    `SME_ASSERT_NEXT(a_status_sticky, stat_reg != sme_pkg::ST_RUN, stat_reg == $past(stat_reg), "status left a final code")

endmodule

### hw/rtl/sme_ctrl.sv
// controller: sequences clearing, accept, read, execute and write-back
`include "stack_machine_executor_unit_defines.svh"

module sme_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sme_pkg::sme_sts_t sts,
    output sme_pkg::sme_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_ARITH = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.md_go)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = S_ARITH;
                end
                else if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = sts.swap ? S_WR2 : S_IDLE;
                end
            end
            S_ARITH:
            begin
                if (sts.md_done && sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WR2:
            begin
                cmd.wr2    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    `SME_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "result word committed over a pending one")

endmodule
